// File: design/pressure_temperature_compensation_core_macros.svh
// Assertion macros shared by the compensation core.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define PTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that two signals agree in every cycle
`define PTC_ASSERT_SAME(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) == (b)) \
        else $error(msg);

`endif

// File: design/ptc_pkg.sv
// Package: widths, register codes, latencies and helpers of the compensation core.
package ptc_pkg;

    localparam int RawW    = 20;
    localparam int CalW    = 48;
    localparam int CfgIdxW = 4;
    localparam int MulW    = 64;
    localparam int MulLat  = 2;
    localparam int DivW    = 64;
    localparam int DivLat  = DivW + 2;

    localparam logic [CfgIdxW-1:0] CfgIdxTemp   = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgIdxPressL = 4'd1;
    localparam logic [CfgIdxW-1:0] CfgIdxPressM = 4'd2;
    localparam logic [CfgIdxW-1:0] CfgIdxPressH = 4'd3;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_div_tag;

    function automatic logic [63:0] ptc_sext16(input logic [15:0] x);
        ptc_sext16 = {{48{x[15]}}, x};
    endfunction

    // (5*tfine + 128) >>> 8, saturated to 16 bits signed
    function automatic logic signed [15:0] ptc_centi(input logic signed [31:0] tf);
        logic signed [31:0] x;
        x = (tf * 32'sd5 + 32'sd128) >>> 8;
        if (x < -32'sd32768) begin
            ptc_centi = -16'sd32768;
        end else if (x > 32'sd32767) begin
            ptc_centi = 16'sd32767;
        end else begin
            ptc_centi = 16'(x);
        end
    endfunction

endpackage

// File: design/ptc_delay.sv
// Shift-register delay line with cleared stages.
module ptc_delay import ptc_pkg::*; #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= '{default: '0};
        end else begin
            r_sr[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_q = r_sr[D-1];
endmodule

// File: design/ptc_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partial products.
module ptc_mul64 import ptc_pkg::*; (
    input  logic            i_clk,
    input  logic [MulW-1:0] i_a,
    input  logic [MulW-1:0] i_b,
    output logic [MulW-1:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_ll <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
        r_lh <= i_a[31:0] * i_b[63:32];
        r_hl <= i_a[63:32] * i_b[31:0];
        // only the low half of the cross terms reaches the result
        r_p  <= r_ll + {r_lh + r_hl, 32'b0};
    end

    assign o_p = r_p;
endmodule

// File: design/ptc_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module ptc_div import ptc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [DivW-1:0] i_num,
    input  logic [DivW-1:0] i_den,
    output logic [DivW-1:0] o_quo,
    output t_div_tag        o_tag
);
    logic            r_vld  [DivW+1];
    logic            r_zero [DivW+1];
    logic            r_neg  [DivW+1];
    logic [DivW-1:0] r_rem  [DivW+1];
    logic [DivW-1:0] r_dvd  [DivW+1];
    logic [DivW-1:0] r_dsr  [DivW+1];
    logic [DivW-1:0] r_quo;
    t_div_tag        r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_den == '0);
        r_neg[0]  <= i_num[DivW-1] ^ i_den[DivW-1];
        r_rem[0]  <= '0;
        r_dvd[0]  <= i_num[DivW-1] ? -i_num : i_num;
        r_dsr[0]  <= i_den[DivW-1] ? -i_den : i_den;
    end

    for (genvar s = 1; s <= DivW; s++) begin : g_step
        logic [DivW-1:0] w_trial;
        logic            w_ge;

        assign w_trial = {r_rem[s-1][DivW-2:0], r_dvd[s-1][DivW-1]};
        assign w_ge    = (w_trial >= r_dsr[s-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[s] <= r_zero[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_dsr[s]  <= r_dsr[s-1];
            r_rem[s]  <= w_ge ? w_trial - r_dsr[s-1] : w_trial;
            // quotient bits enter from the bottom as dividend bits leave the top
            r_dvd[s]  <= {r_dvd[s-1][DivW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else begin
            r_tag.vld <= r_vld[DivW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag.zero <= r_zero[DivW];
        r_quo      <= r_neg[DivW] ? -r_dvd[DivW] : r_dvd[DivW];
    end

    assign o_quo = r_quo;
    assign o_tag = r_tag;
endmodule

// File: design/pressure_temperature_compensation_core.sv
// Top level: temperature and pressure compensation pipeline with calibration registers.
//
// Usage: load the four 48-bit calibration registers through the write channel
// (i_cfg_valid/o_cfg_ready, i_cfg_index 0..3, i_cfg_data; other indexes are
// ignored, o_cfg_ready is always high). Then present one raw temperature and
// pressure pair with start; an item is taken at every edge where start is high
// and busy is low. busy stays low, so an item may be started in every cycle.
// Throughput: one item per cycle. Each item passes the pipelined multipliers,
// the divider with one quotient bit per stage, and the adder stages.
// Each result stands on the outputs for the single cycle that o_done marks;
// the receiver cannot stall, and results leave in the order items came in.
// Reset clears the calibration registers to 0 and drops every item in flight.
// A zero pressure divisor gives pressure 0 with o_divide_by_zero set.
`include "pressure_temperature_compensation_core_macros.svh"

module pressure_temperature_compensation_core import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [RawW-1:0]    i_raw_temperature,
    input  logic [RawW-1:0]    i_raw_pressure,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CalW-1:0]    i_cfg_data,
    output logic               o_done,
    output logic signed [15:0] o_temperature_centi,
    output logic signed [31:0] o_fine_temperature,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_divide_by_zero
);
    localparam int AdcDly = 2 * MulLat + 1;
    localparam int DivDly = 3 * MulLat + 2;
    localparam int TotDly = 5 * MulLat + 4 + DivLat;

    logic [CalW-1:0] r_cal_t, r_cal_pl, r_cal_pm, r_cal_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pl <= '0;
            r_cal_pm <= '0;
            r_cal_ph <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgIdxTemp:   r_cal_t  <= i_cfg_data;
                CfgIdxPressL: r_cal_pl <= i_cfg_data;
                CfgIdxPressM: r_cal_pm <= i_cfg_data;
                CfgIdxPressH: r_cal_ph <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [63:0]        w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_cal_t[15:0];
    assign w_t2 = $signed(r_cal_t[31:16]);
    assign w_t3 = $signed(r_cal_t[47:32]);
    assign w_p1 = {48'b0, r_cal_pl[15:0]};
    assign w_p2 = ptc_sext16(r_cal_pl[31:16]);
    assign w_p3 = ptc_sext16(r_cal_pl[47:32]);
    assign w_p4 = ptc_sext16(r_cal_pm[15:0]);
    assign w_p5 = ptc_sext16(r_cal_pm[31:16]);
    assign w_p6 = ptc_sext16(r_cal_pm[47:32]);
    assign w_p7 = ptc_sext16(r_cal_ph[15:0]);
    assign w_p8 = ptc_sext16(r_cal_ph[31:16]);
    assign w_p9 = ptc_sext16(r_cal_ph[47:32]);

    // temperature: stages A to D
    logic               w_acc;
    logic signed [17:0] w_d1, w_d2;
    logic signed [21:0] w_sqs;

    assign w_acc = start & ~busy;
    assign w_d1  = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_d2  = $signed({2'b0, i_raw_temperature[19:4]}) - $signed({2'b0, w_t1});

    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic signed [33:0] r_a_prod1;
    logic signed [35:0] r_a_sq;
    logic signed [22:0] r_b_v1;
    logic signed [37:0] r_b_prod2;
    logic signed [31:0] r_c_tf, r_d_tf;
    logic signed [15:0] r_d_tc;
    logic [63:0]        r_d_pa;
    logic [RawW-1:0]    r_a_adcp, r_b_adcp, r_c_adcp, r_d_adcp;

    assign w_sqs = $signed(r_a_sq[33:12]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= w_acc;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod1 <= w_d1 * w_t2;
        r_a_sq    <= w_d2 * w_d2;
        r_a_adcp  <= i_raw_pressure;
        r_b_v1    <= 23'(r_a_prod1 >>> 11);
        r_b_prod2 <= w_sqs * w_t3;
        r_b_adcp  <= r_a_adcp;
        r_c_tf    <= 32'(r_b_v1) + 32'(r_b_prod2 >>> 14);
        r_c_adcp  <= r_b_adcp;
        r_d_tf    <= r_c_tf;
        r_d_tc    <= ptc_centi(r_c_tf);
        r_d_pa    <= 64'(r_c_tf) - 64'sd128000;
        r_d_adcp  <= r_c_adcp;
    end

    // pressure: first products
    logic [63:0] w_pa2, w_pap5, w_pap2, w_pa2p6, w_pa2p3;
    logic [63:0] w_pap5_d, w_pap2_d;

    ptc_mul64 u_m_pa2  (.i_clk(i_clk), .i_a(r_d_pa), .i_b(r_d_pa), .o_p(w_pa2));
    ptc_mul64 u_m_pap5 (.i_clk(i_clk), .i_a(r_d_pa), .i_b(w_p5),   .o_p(w_pap5));
    ptc_mul64 u_m_pap2 (.i_clk(i_clk), .i_a(r_d_pa), .i_b(w_p2),   .o_p(w_pap2));
    ptc_mul64 u_m_p6   (.i_clk(i_clk), .i_a(w_pa2),  .i_b(w_p6),   .o_p(w_pa2p6));
    ptc_mul64 u_m_p3   (.i_clk(i_clk), .i_a(w_pa2),  .i_b(w_p3),   .o_p(w_pa2p3));

    ptc_delay #(.W(128), .D(MulLat)) u_dly_pa (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_d({w_pap5, w_pap2}), .o_q({w_pap5_d, w_pap2_d})
    );

    logic [RawW-1:0] w_adcp_d;

    ptc_delay #(.W(RawW), .D(AdcDly)) u_dly_adc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d(r_d_adcp), .o_q(w_adcp_d)
    );

    logic [63:0] r_f_pb, r_f_pas, r_g_num, r_g_pas;
    logic [20:0] w_prr;

    assign w_prr = 21'd1048576 - {1'b0, w_adcp_d};

    always_ff @(posedge i_clk) begin
        r_f_pb  <= w_pa2p6 + (w_pap5_d << 17) + (w_p4 << 35);
        r_f_pas <= 64'($signed(w_pa2p3) >>> 8) + (w_pap2_d << 12) + (64'd1 << 47);
        r_g_num <= ({43'b0, w_prr} << 31) - r_f_pb;
        r_g_pas <= r_f_pas;
    end

    logic [63:0] w_den_p, w_num;

    ptc_mul64 u_m_p1   (.i_clk(i_clk), .i_a(r_g_pas), .i_b(w_p1),     .o_p(w_den_p));
    ptc_mul64 u_m_3125 (.i_clk(i_clk), .i_a(r_g_num), .i_b(64'd3125), .o_p(w_num));

    logic w_div_vld;

    ptc_delay #(.W(1), .D(DivDly)) u_dly_vld (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d(r_d_vld), .o_q(w_div_vld)
    );

    logic [63:0] w_q;
    t_div_tag    w_tag;

    ptc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(w_div_vld),
        .i_num(w_num), .i_den(64'($signed(w_den_p) >>> 33)),
        .o_quo(w_q), .o_tag(w_tag)
    );

    // pressure: second-order correction
    logic [63:0] w_x, w_p9x, w_p8q, w_x_d, w_p9xx, w_p8q_d, w_q_d;
    t_div_tag    w_tag_d;

    assign w_x = 64'($signed(w_q) >>> 13);

    ptc_mul64 u_m_p9  (.i_clk(i_clk), .i_a(w_p9),  .i_b(w_x),   .o_p(w_p9x));
    ptc_mul64 u_m_p8  (.i_clk(i_clk), .i_a(w_p8),  .i_b(w_q),   .o_p(w_p8q));
    ptc_mul64 u_m_p9x (.i_clk(i_clk), .i_a(w_p9x), .i_b(w_x_d), .o_p(w_p9xx));

    ptc_delay #(.W(64), .D(MulLat)) u_dly_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d(w_x), .o_q(w_x_d)
    );
    ptc_delay #(.W(64), .D(MulLat)) u_dly_p8q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d(w_p8q), .o_q(w_p8q_d)
    );
    ptc_delay #(.W(66), .D(2 * MulLat)) u_dly_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d({w_tag, w_q}), .o_q({w_tag_d, w_q_d})
    );

    logic [63:0] r_i_sum;
    logic        r_i_vld, r_i_zero, r_pr_vld, r_pr_zero;
    logic [31:0] r_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld  <= 1'b0;
            r_pr_vld <= 1'b0;
        end else begin
            r_i_vld  <= w_tag_d.vld;
            r_pr_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_sum   <= w_q_d + 64'($signed(w_p9xx) >>> 25) + 64'($signed(w_p8q_d) >>> 19);
        r_i_zero  <= w_tag_d.zero;
        r_pr_zero <= r_i_zero;
        // drop the pressure when the divisor was zero
        r_pr      <= r_i_zero ? 32'd0
                              : 32'($signed(r_i_sum) >>> 8) + 32'(w_p7 << 4);
    end

    // temperature results wait beside the pressure path
    logic [48:0] w_tdly;

    ptc_delay #(.W(49), .D(TotDly)) u_dly_temp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_d({r_d_vld, r_d_tc, r_d_tf}), .o_q(w_tdly)
    );

    assign o_done              = w_tdly[48];
    assign o_temperature_centi = $signed(w_tdly[47:32]);
    assign o_fine_temperature  = $signed(w_tdly[31:0]);
    assign o_pressure_q24_8    = r_pr;
    assign o_divide_by_zero    = r_pr_zero;

    `PTC_ASSERT_SAME(a_path_align, i_clk, i_rst_n, r_pr_vld, o_done, "pressure and temperature paths out of step")
    `PTC_ASSERT_IMPL(a_zero_press, i_clk, i_rst_n, o_done && o_divide_by_zero, o_pressure_q24_8 == 32'd0, "pressure not cleared on zero divisor")
endmodule
